>>> hw/rtl/bomd_pkg.sv
// Shared types, codes and constants of the byte order mark text decoder.
package bomd_pkg;

  // Default number of entries in the queue between front and back end.
  localparam int unsigned DefQueueDepth = 4;

  // Width of a decoded code point.
  localparam int unsigned CpW = 31;

  // Decode modes; the numeric value is also the reported encoding.
  typedef enum logic [2:0] {
    ModePlain   = 3'd0,
    ModeUtf8Bom = 3'd1,
    ModeUtf16Le = 3'd2,
    ModeUtf16Be = 3'd3,
    ModeUtf32Le = 3'd4,
    ModeUtf32Be = 3'd5,
    ModeDetect  = 3'd6
  } bomd_mode_e;

  // Error codes carried with each result.
  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrMissing = 2'd1,
    ErrStray   = 2'd2
  } bomd_err_e;

  // Code points that take part in newline folding.
  localparam logic [CpW-1:0] CpNul  = 31'h0000_0000;
  localparam logic [CpW-1:0] CpLf   = 31'h0000_000A;
  localparam logic [CpW-1:0] CpVt   = 31'h0000_000B;
  localparam logic [CpW-1:0] CpFf   = 31'h0000_000C;
  localparam logic [CpW-1:0] CpCr   = 31'h0000_000D;
  localparam logic [CpW-1:0] CpSub  = 31'h0000_001A;
  localparam logic [CpW-1:0] CpNel  = 31'h0000_0085;
  localparam logic [CpW-1:0] CpLsep = 31'h0000_2028;
  localparam logic [CpW-1:0] CpPsep = 31'h0000_2029;

  // UTF-16 surrogate handling.
  localparam logic [15:0] SurMask   = 16'hFC00;
  localparam logic [15:0] SurHigh   = 16'hD800;
  localparam logic [15:0] SurLow    = 16'hDC00;
  localparam logic [20:0] SupplBase = 21'h01_0000;

  // One queue entry: a group of bytes to decode, optionally closing the stream.
  typedef struct packed {
    bomd_mode_e       mode;
    logic [3:0][7:0]  bytes;
    logic [2:0]       start;
    logic [2:0]       stop;
    logic             stream_end;
  } bomd_entry_t;

  // One result item without its last flag.
  typedef struct packed {
    logic [CpW-1:0] code_point;
    bomd_err_e      error_kind;
    logic           stream_good;
    bomd_mode_e     encoding;
    logic           end_marker;
  } bomd_res_t;

endpackage

>>> hw/rtl/bomd_if.sv
// Valid/ready channel interfaces for the decoder input and result streams.
interface bomd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface bomd_out_if;
  logic                     valid;
  logic                     ready;
  logic [bomd_pkg::CpW-1:0] code_point;
  logic [1:0]               error_kind;
  logic                     stream_good;
  logic [2:0]               detected_encoding;
  logic                     end_marker;
  logic                     last_result;

  modport source (output valid, output code_point, output error_kind, output stream_good,
                  output detected_encoding, output end_marker, output last_result,
                  input ready);
  modport sink   (input valid, input code_point, input error_kind, input stream_good,
                  input detected_encoding, input end_marker, input last_result,
                  output ready);
endinterface

>>> hw/rtl/bomd_fifo.sv
// Small queue of decode entries between the front and back end.
module bomd_fifo #(
  parameter int unsigned Depth = bomd_pkg::DefQueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bomd_pkg::bomd_entry_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output bomd_pkg::bomd_entry_t head_o,
  output logic                  head_valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bomd_pkg::bomd_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/bomd_front.sv
// Front end: accepts byte beats, buffers and checks the byte order mark, builds entries.
module bomd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bomd_in_if.sink               in_i,
  input  logic                  full_i,
  output logic                  push_o,
  output bomd_pkg::bomd_entry_t entry_o
);

  localparam logic [7:0] ByteEf = 8'hEF;
  localparam logic [7:0] ByteBb = 8'hBB;
  localparam logic [7:0] ByteBf = 8'hBF;
  localparam logic [7:0] ByteFf = 8'hFF;
  localparam logic [7:0] ByteFe = 8'hFE;
  localparam logic [7:0] ByteNul = 8'h00;

  typedef struct packed {
    bomd_pkg::bomd_mode_e mode;
    logic [2:0]           skip;
  } det_t;

  // Compare the first n buffered bytes against the known marks.
  function automatic det_t detect(logic [3:0][7:0] b, logic [2:0] n);
    det_t r;
    r.mode = bomd_pkg::ModePlain;
    r.skip = 3'd0;
    if (n >= 3'd3 && b[0] == ByteEf && b[1] == ByteBb && b[2] == ByteBf) begin
      r.mode = bomd_pkg::ModeUtf8Bom;
      r.skip = 3'd3;
    end else if (n >= 3'd2 && b[0] == ByteFf && b[1] == ByteFe) begin
      if (n >= 3'd4 && b[2] == ByteNul && b[3] == ByteNul) begin
        r.mode = bomd_pkg::ModeUtf32Le;
        r.skip = 3'd4;
      end else begin
        r.mode = bomd_pkg::ModeUtf16Le;
        r.skip = 3'd2;
      end
    end else if (n >= 3'd4 && b[0] == ByteNul && b[1] == ByteNul && b[2] == ByteFe &&
                 b[3] == ByteFf) begin
      r.mode = bomd_pkg::ModeUtf32Be;
      r.skip = 3'd4;
    end else if (n >= 3'd2 && b[0] == ByteFe && b[1] == ByteFf) begin
      r.mode = bomd_pkg::ModeUtf16Be;
      r.skip = 3'd2;
    end
    return r;
  endfunction

  bomd_pkg::bomd_mode_e mode_q, mode_d;
  logic [1:0]           cnt_q, cnt_d;
  logic [2:0][7:0]      bom_q;
  logic                 bom_we;
  logic                 accept;
  logic [3:0][7:0]      det_bytes;
  logic [2:0]           det_n;
  det_t                 det;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;

  // Classify each accepted beat and form the queue entry.
  always_comb begin
    det_bytes = {in_i.data_byte, bom_q[2], bom_q[1], bom_q[0]};
    det_n     = in_i.stream_end ? {1'b0, cnt_q} : 3'd4;
    det       = detect(det_bytes, det_n);
    mode_d    = mode_q;
    cnt_d     = cnt_q;
    bom_we    = 1'b0;
    push_o    = 1'b0;
    entry_o            = '0;
    entry_o.mode       = mode_q;
    entry_o.bytes[0]   = in_i.data_byte;
    entry_o.stream_end = in_i.stream_end;
    if (accept) begin
      if (in_i.stream_end) begin
        push_o = 1'b1;
        if (mode_q == bomd_pkg::ModeDetect) begin
          entry_o.mode  = det.mode;
          entry_o.bytes = det_bytes;
          entry_o.start = det.skip;
          entry_o.stop  = det_n;
        end
        mode_d = bomd_pkg::ModeDetect;
        cnt_d  = '0;
      end else if (mode_q == bomd_pkg::ModeDetect) begin
        if (cnt_q == 2'd3) begin
          push_o        = 1'b1;
          entry_o.mode  = det.mode;
          entry_o.bytes = det_bytes;
          entry_o.start = det.skip;
          entry_o.stop  = det_n;
          mode_d        = det.mode;
          cnt_d         = '0;
        end else begin
          bom_we = 1'b1;
          cnt_d  = 2'(cnt_q + 2'd1);
        end
      end else begin
        push_o       = 1'b1;
        entry_o.stop = 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= bomd_pkg::ModeDetect;
      cnt_q  <= '0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
    end
  end

  // Mark buffer holds payload only.
  always_ff @(posedge clk_i) begin
    if (bom_we) begin
      bom_q[cnt_q] <= in_i.data_byte;
    end
  end

endmodule

>>> hw/rtl/bomd_back.sv
// Back end: decodes queued bytes, one per unstalled cycle, folds newlines, drives results.
module bomd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  bomd_pkg::bomd_entry_t head_i,
  output logic                  pop_o,
  bomd_out_if.source            out_o
);

  localparam int unsigned CpW = bomd_pkg::CpW;

  // Count of leading one bits of a byte.
  function automatic logic [3:0] lead_ones(logic [7:0] b);
    logic [3:0] n;
    logic       done;
    n    = '0;
    done = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!done) begin
        if (b[i]) begin
          n = 4'(n + 4'd1);
        end else begin
          done = 1'b1;
        end
      end
    end
    return n;
  endfunction

  // Decoder state.
  logic [CpW-1:0] partial_q, partial_d;
  logic [2:0]     pend_q, pend_d;
  logic [15:0]    hs_q, hs_d;
  logic           perr_q, perr_d;
  logic           swallow_q, swallow_d;
  logic           good_q, good_d;
  // Per-entry sequencing.
  logic [2:0]     cnt_q, cnt_d;
  logic           flushed_q, flushed_d;
  // Hold stage and output register.
  logic                h_valid_q, h_valid_d, h_final_q, h_final_d;
  bomd_pkg::bomd_res_t h_res_q;
  logic                o_valid_q, o_valid_d, o_last_q;
  bomd_pkg::bomd_res_t o_res_q;

  logic                o_free, step_en, step_final, final_step, move_h;
  logic [2:0]          idx;
  logic                feeding, close;
  logic [7:0]          cur_byte;
  logic [3:0]          lead_n;
  logic [15:0]         unit;
  logic [20:0]         pair_cp;
  logic [CpW-1:0]      le_val, be_val;
  logic                raw_valid, raw_endm, swallowed, r_valid;
  logic [CpW-1:0]      raw_cp;
  bomd_pkg::bomd_err_e raw_err;
  bomd_pkg::bomd_res_t res;

  // One decode step: a byte, the stream-end flush, the closing newline, or retiring a spent entry.
  always_comb begin
    o_free   = !o_valid_q || out_o.ready;
    step_en  = head_valid_i && (!h_valid_q || o_free);
    idx      = 3'(head_i.start + cnt_q);
    feeding  = idx < head_i.stop;
    cur_byte = head_i.bytes[idx[1:0]];
    lead_n   = lead_ones(cur_byte);
    unit     = (head_i.mode == bomd_pkg::ModeUtf16Le) ? {cur_byte, partial_q[7:0]}
                                                      : {partial_q[7:0], cur_byte};
    pair_cp  = 21'({hs_q[9:0], unit[9:0]}) + bomd_pkg::SupplBase;
    le_val   = partial_q | (CpW'(cur_byte) << {pend_q[1:0], 3'b000});
    be_val   = {partial_q[CpW-9:0], cur_byte};

    partial_d  = partial_q;
    pend_d     = pend_q;
    hs_d       = hs_q;
    perr_d     = perr_q;
    cnt_d      = cnt_q;
    flushed_d  = flushed_q;
    raw_valid  = 1'b0;
    raw_cp     = '0;
    raw_err    = bomd_pkg::ErrNone;
    raw_endm   = 1'b0;
    step_final = 1'b0;
    close      = 1'b0;

    if (feeding) begin
      step_final = (3'(idx + 3'd1) == head_i.stop) && !head_i.stream_end;
      cnt_d      = 3'(cnt_q + 3'd1);
      case (head_i.mode)
        bomd_pkg::ModeUtf16Le, bomd_pkg::ModeUtf16Be: begin
          if (pend_q == 3'd0) begin
            partial_d = CpW'(cur_byte);
            pend_d    = 3'd1;
          end else begin
            pend_d    = '0;
            partial_d = '0;
            if (hs_q != '0) begin
              raw_valid = 1'b1;
              hs_d      = '0;
              if ((unit & bomd_pkg::SurMask) == bomd_pkg::SurLow) begin
                raw_cp = CpW'(pair_cp);
              end else begin
                raw_cp  = CpW'(hs_q);
                raw_err = bomd_pkg::ErrMissing;
              end
            end else if ((unit & bomd_pkg::SurMask) == bomd_pkg::SurHigh) begin
              hs_d = unit;
            end else begin
              raw_valid = 1'b1;
              raw_cp    = CpW'(unit);
              if ((unit & bomd_pkg::SurMask) == bomd_pkg::SurLow) begin
                raw_err = bomd_pkg::ErrStray;
              end
            end
          end
        end
        bomd_pkg::ModeUtf32Le, bomd_pkg::ModeUtf32Be: begin
          partial_d = (head_i.mode == bomd_pkg::ModeUtf32Le) ? le_val : be_val;
          pend_d    = 3'(pend_q + 3'd1);
          if (pend_q == 3'd3) begin
            raw_valid = 1'b1;
            raw_cp    = partial_d;
            partial_d = '0;
            pend_d    = '0;
          end
        end
        default: begin
          // UTF-8, with or without a mark.
          if (pend_q == 3'd0) begin
            if (lead_n == 4'd0) begin
              raw_valid = 1'b1;
              raw_cp    = CpW'(cur_byte);
            end else if (lead_n == 4'd1) begin
              raw_valid = 1'b1;
              raw_cp    = CpW'(cur_byte);
              raw_err   = bomd_pkg::ErrStray;
            end else begin
              partial_d = CpW'(cur_byte & (8'hFF >> lead_n));
              pend_d    = 3'(lead_n - 4'd1);
              perr_d    = 1'b0;
            end
          end else begin
            if (cur_byte[7:6] == 2'b10) begin
              partial_d = {partial_q[CpW-7:0], cur_byte[5:0]};
            end else begin
              perr_d = 1'b1;
            end
            pend_d = 3'(pend_q - 3'd1);
            if (pend_q == 3'd1) begin
              raw_valid = 1'b1;
              raw_cp    = partial_d;
              raw_err   = perr_d ? bomd_pkg::ErrMissing : bomd_pkg::ErrNone;
              partial_d = '0;
              perr_d    = 1'b0;
            end
          end
        end
      endcase
    end else if (head_i.stream_end && !flushed_q) begin
      // Report an unfinished item before the closing newline.
      flushed_d = 1'b1;
      if (pend_q != '0 || hs_q != '0) begin
        raw_valid = 1'b1;
        raw_err   = bomd_pkg::ErrMissing;
        case (head_i.mode)
          bomd_pkg::ModePlain, bomd_pkg::ModeUtf8Bom: raw_cp = partial_q;
          bomd_pkg::ModeUtf16Le, bomd_pkg::ModeUtf16Be: raw_cp = CpW'(hs_q);
          default: raw_cp = '0;
        endcase
      end
    end else if (head_i.stream_end) begin
      raw_valid  = 1'b1;
      raw_cp     = bomd_pkg::CpSub;
      raw_endm   = 1'b1;
      step_final = 1'b1;
      close      = 1'b1;
    end else begin
      step_final = 1'b1;
    end

    // Newline folding, line feed swallowing and the sticky good flag.
    swallowed = swallow_q && raw_cp == bomd_pkg::CpLf && raw_err == bomd_pkg::ErrNone;
    swallow_d = swallow_q;
    good_d    = good_q;
    if (raw_valid) begin
      swallow_d = !swallowed && (raw_cp inside {bomd_pkg::CpNul, bomd_pkg::CpSub,
                                                bomd_pkg::CpCr});
      if (raw_err != bomd_pkg::ErrNone) begin
        good_d = 1'b0;
      end
    end
    res.code_point  = (raw_cp inside {bomd_pkg::CpNul, bomd_pkg::CpSub, bomd_pkg::CpCr,
                                      bomd_pkg::CpLf, bomd_pkg::CpVt, bomd_pkg::CpFf,
                                      bomd_pkg::CpNel, bomd_pkg::CpLsep, bomd_pkg::CpPsep})
                      ? bomd_pkg::CpLf : raw_cp;
    res.error_kind  = raw_err;
    res.stream_good = good_d;
    res.encoding    = head_i.mode;
    res.end_marker  = raw_endm;
    r_valid         = step_en && raw_valid && !swallowed;

    // The closing newline returns the decoder to its reset state.
    if (close) begin
      partial_d = '0;
      pend_d    = '0;
      hs_d      = '0;
      perr_d    = 1'b0;
      swallow_d = 1'b0;
      good_d    = 1'b1;
    end

    final_step = step_en && step_final;
    pop_o      = final_step;
    if (step_final) begin
      cnt_d     = '0;
      flushed_d = 1'b0;
    end

    // A held result leaves to a free output once a later one exists or its entry is done.
    move_h    = h_valid_q && o_free && (h_final_q || r_valid);
    h_valid_d = r_valid ? 1'b1 : (move_h ? 1'b0 : h_valid_q);
    h_final_d = r_valid ? final_step : (h_final_q || final_step);
    o_valid_d = move_h || (o_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      pend_q    <= '0;
      hs_q      <= '0;
      perr_q    <= 1'b0;
      swallow_q <= 1'b0;
      good_q    <= 1'b1;
      cnt_q     <= '0;
      flushed_q <= 1'b0;
      h_valid_q <= 1'b0;
      h_final_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (step_en) begin
        partial_q <= partial_d;
        pend_q    <= pend_d;
        hs_q      <= hs_d;
        perr_q    <= perr_d;
        swallow_q <= swallow_d;
        good_q    <= good_d;
        cnt_q     <= cnt_d;
        flushed_q <= flushed_d;
      end
      h_valid_q <= h_valid_d;
      h_final_q <= h_final_d;
      o_valid_q <= o_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (r_valid) begin
      h_res_q <= res;
    end
    if (move_h) begin
      o_res_q  <= h_res_q;
      o_last_q <= h_final_q;
    end
  end

  assign out_o.valid             = o_valid_q;
  assign out_o.code_point        = o_res_q.code_point;
  assign out_o.error_kind        = o_res_q.error_kind;
  assign out_o.stream_good       = o_res_q.stream_good;
  assign out_o.detected_encoding = o_res_q.encoding;
  assign out_o.end_marker        = o_res_q.end_marker;
  assign out_o.last_result       = o_last_q;

endmodule

>>> hw/rtl/unicode_bom_decoder_top.sv
// Top level of the byte order mark detecting UTF-8/16/32 text decoder.
//
// Channel  Direction  Payload                                         Handshake
// in_i     sink       data_byte, stream_end                           valid/ready
// out_o    source     code_point, error_kind, stream_good,            valid/ready
//                     detected_encoding, end_marker, last_result
//
// Once the encoding is known the block takes one byte beat per cycle while the queue
// has room; the back end decodes one byte per cycle while its results are not stalled.
// The beat that completes the four-byte mark check replays up to four bytes; a
// stream-end beat takes its replayed bytes plus a flush and a closing step.
// A result passes through the queue, the hold stage and the output register to out_o.
// Reset is asynchronous and returns the block to mark detection with an empty queue.
// A queue of QueueDepth entries, a one-result hold stage and the output register let
// input beats continue while results wait on out_o.ready.
module unicode_bom_decoder_top #(
  parameter int unsigned QueueDepth = bomd_pkg::DefQueueDepth
) (
  input logic        clk_i,
  input logic        rst_ni,
  bomd_in_if.sink    in_i,
  bomd_out_if.source out_o
);

  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  head_valid;
  bomd_pkg::bomd_entry_t push_entry;
  bomd_pkg::bomd_entry_t head_entry;

  // Mark detection and entry building.
  bomd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // Decoupling queue.
  bomd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head_entry),
    .head_valid_o (head_valid)
  );

  // Decoding and result output.
  bomd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_entry),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

>>> hw/rtl/bomd_checker.sv
// Port-level checks of the decoder result stream, bound to the top level.
module bomd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  bomd_out_if.source out_i
);

  logic beat;
  logic saw_end_q;

  assign beat = out_i.valid && out_i.ready;

  // Remember that the last result beat closed a stream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saw_end_q <= 1'b0;
    end else if (beat) begin
      saw_end_q <= out_i.end_marker;
    end
  end

  // A stalled result beat holds its value.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_i.valid && !out_i.ready |=> out_i.valid && $stable(out_i.code_point) &&
    $stable(out_i.last_result))
    else $error("result changed while stalled");

  // An error always clears the good flag shown with it.
  a_err_clears_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && out_i.error_kind != bomd_pkg::ErrNone |-> !out_i.stream_good)
    else $error("error reported with good flag set");

  // The closing newline is error free, folded and ends its beat group.
  a_end_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_i.valid && out_i.end_marker |-> out_i.last_result &&
    out_i.code_point == bomd_pkg::CpLf && out_i.error_kind == bomd_pkg::ErrNone)
    else $error("malformed closing newline");

  // The first result of a new stream starts from a clean good flag.
  a_fresh_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat && saw_end_q |-> out_i.stream_good == (out_i.error_kind == bomd_pkg::ErrNone))
    else $error("good flag carried over a stream end");

endmodule

bind unicode_bom_decoder_top bomd_checker u_bomd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .out_i  (out_o)
);
